// ===== rtl/core/org_pkg.sv =====
// Shared types and constants for the overheat recovery gate.
package org_pkg;

	// Field and register widths.
	localparam int NOW_W         = 48;
	localparam int TIME_BITS_DEF = 48;
	localparam int TEMP_W        = 13;
	localparam int VOLT_W        = 16;
	localparam int FREQ_W        = 22;
	localparam int COOL_W        = 22;
	localparam int VSTEP_W       = 10;
	localparam int FSTEP_W       = 20;
	localparam int CFG_W         = 22;
	localparam int CFG_IDX_W     = 3;

	// Configuration reset values.
	localparam logic signed [TEMP_W-1:0] ASIC_SAFE_RST = 13'sd1200;
	localparam logic signed [TEMP_W-1:0] VREG_SAFE_RST = 13'sd1360;
	localparam logic [COOL_W-1:0]        MIN_COOL_RST  = 22'd60000;
	localparam logic [VSTEP_W-1:0]       VSTEP_RST     = 10'd50;
	localparam logic [FSTEP_W-1:0]       FSTEP_RST     = 20'd50000;
	localparam logic [VOLT_W-1:0]        MIN_VOLT_RST  = 16'd0;
	localparam logic [FREQ_W-1:0]        MIN_FREQ_RST  = 22'd0;

	// Item actions.
	typedef enum logic {
		ACT_BEGIN = 1'b0,
		ACT_EVAL  = 1'b1
	} action_t;

	// Recovery status codes.
	typedef enum logic [2:0] {
		ST_INACTIVE  = 3'd0,
		ST_WAIT_OFF  = 3'd1,
		ST_WAIT_TELE = 3'd2,
		ST_WAIT_ASIC = 3'd3,
		ST_WAIT_MIN  = 3'd4,
		ST_WAIT_VREG = 3'd5,
		ST_READY     = 3'd6,
		ST_INVALID   = 3'd7
	} status_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ASIC_SAFE = 3'd0,
		REG_VREG_SAFE = 3'd1,
		REG_MIN_COOL  = 3'd2,
		REG_VSTEP     = 3'd3,
		REG_FSTEP     = 3'd4,
		REG_MIN_VOLT  = 3'd5,
		REG_MIN_FREQ  = 3'd6
	} cfg_reg_t;

endpackage

// ===== rtl/core/overheat_recovery_gate.sv =====
// Top level of the overheat recovery gate: input stage, decision logic and result register.
// An accepted transaction is held in the input stage, then passes through the decision logic into the result register.
// Throughput: one transaction per cycle while result_stall is low; the single pass from the recovery state
// registers through the decision logic back into them sets this figure.
// Reset clears the recovery state and the valid flags and loads the configuration
// registers with their defaults; no clearing pass is needed.
module overheat_recovery_gate #(
	parameter int TIME_BITS = org_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [org_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [org_pkg::CFG_W-1:0]          cfg_data,
	// Item channel.
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               action,
	input  logic [org_pkg::NOW_W-1:0]          now_ms,
	input  logic [org_pkg::VOLT_W-1:0]         orig_voltage_mv,
	input  logic [org_pkg::FREQ_W-1:0]         original_freq_khz,
	input  logic                               power_off_safe,
	input  logic                               vreg_temp_valid,
	input  logic signed [org_pkg::TEMP_W-1:0]  vreg_temp,
	input  logic                               asic_temp_valid,
	input  logic signed [org_pkg::TEMP_W-1:0]  asic_temp,
	// Result channel.
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               accepted,
	output logic [2:0]                         status,
	output logic                               targets_valid,
	output logic [org_pkg::VOLT_W-1:0]         target_voltage_mv,
	output logic [org_pkg::FREQ_W-1:0]         reduced_freq_khz
);
	import org_pkg::*;

	// Effective time width: the time field is taken modulo 2^TW, TW being the smaller of TIME_BITS and NOW_W.
	localparam int TW = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

	// Configuration registers.
	logic signed [TEMP_W-1:0] asic_safe_q;
	logic signed [TEMP_W-1:0] vreg_safe_q;
	logic [COOL_W-1:0]        min_cool_q;
	logic [VSTEP_W-1:0]       vstep_q;
	logic [FSTEP_W-1:0]       fstep_q;
	logic [VOLT_W-1:0]        min_volt_q;
	logic [FREQ_W-1:0]        min_freq_q;

	// Recovery state.
	logic              armed_q;
	logic [TW-1:0]     start_time_q;
	logic [TW-1:0]     cooling_start_q;
	logic [VOLT_W-1:0] saved_volt_q;
	logic [FREQ_W-1:0] saved_freq_q;

	// Input stage.
	logic                     vld_s1;
	action_t                  action_s1;
	logic [TW-1:0]            now_s1;
	logic [VOLT_W-1:0]        volt_s1;
	logic [FREQ_W-1:0]        freq_s1;
	logic                     off_ok_s1;
	logic                     vreg_vld_s1;
	logic signed [TEMP_W-1:0] vreg_temp_s1;
	logic                     asic_vld_s1;
	logic signed [TEMP_W-1:0] asic_temp_s1;

	// Result register.
	logic              res_vld_q;
	logic              accepted_q;
	status_t           status_q;
	logic              tvalid_q;
	logic [VOLT_W-1:0] red_volt_q;
	logic [FREQ_W-1:0] red_freq_q;

	// Decision logic signals.
	logic              out_free;
	logic              adv;
	logic              begin_ok;
	status_t           eval_st;
	logic              cool_restart;
	logic [TW-1:0]     elapsed;
	logic              armed_n;
	logic [VOLT_W-1:0] saved_volt_n;
	logic [FREQ_W-1:0] saved_freq_n;
	logic              tvalid_n;
	logic [VOLT_W:0]   volt_limit;
	logic [FREQ_W:0]   freq_limit;
	logic [VOLT_W-1:0] red_volt_n;
	logic [FREQ_W-1:0] red_freq_n;

	// Handshake: the input stage moves on whenever the result register is free.
	assign out_free   = !res_vld_q || !result_stall;
	assign adv        = vld_s1 && out_free;
	assign item_stall = vld_s1 && !out_free;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asic_safe_q <= ASIC_SAFE_RST;
			vreg_safe_q <= VREG_SAFE_RST;
			min_cool_q  <= MIN_COOL_RST;
			vstep_q     <= VSTEP_RST;
			fstep_q     <= FSTEP_RST;
			min_volt_q  <= MIN_VOLT_RST;
			min_freq_q  <= MIN_FREQ_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ASIC_SAFE: asic_safe_q <= signed'(cfg_data[TEMP_W-1:0]);
				REG_VREG_SAFE: vreg_safe_q <= signed'(cfg_data[TEMP_W-1:0]);
				REG_MIN_COOL:  min_cool_q  <= cfg_data[COOL_W-1:0];
				REG_VSTEP:     vstep_q     <= cfg_data[VSTEP_W-1:0];
				REG_FSTEP:     fstep_q     <= cfg_data[FSTEP_W-1:0];
				REG_MIN_VOLT:  min_volt_q  <= cfg_data[VOLT_W-1:0];
				REG_MIN_FREQ:  min_freq_q  <= cfg_data[FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!item_stall) begin
			vld_s1 <= item_valid;
		end
	end

	// Input stage payload, captured with each accepted transaction.
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			action_s1    <= action_t'(action);
			now_s1       <= now_ms[TW-1:0];
			volt_s1      <= orig_voltage_mv;
			freq_s1      <= original_freq_khz;
			off_ok_s1    <= power_off_safe;
			vreg_vld_s1  <= vreg_temp_valid;
			vreg_temp_s1 <= vreg_temp;
			asic_vld_s1  <= asic_temp_valid;
			asic_temp_s1 <= asic_temp;
		end
	end

	// Status of an evaluate transaction, in priority order.
	always_comb begin
		cool_restart = 1'b0;
		elapsed      = now_s1 - cooling_start_q;
		if (!armed_q) begin
			eval_st = ST_INACTIVE;
		end else if (now_s1 < start_time_q || now_s1 < cooling_start_q) begin
			eval_st = ST_INVALID;
		end else if (!off_ok_s1) begin
			eval_st = ST_WAIT_OFF;
		end else if (!vreg_vld_s1) begin
			eval_st = ST_WAIT_TELE;
		end else if (asic_vld_s1 && asic_temp_s1 > asic_safe_q) begin
			eval_st      = ST_WAIT_ASIC;
			cool_restart = 1'b1;
		end else if (elapsed < {{(TW-COOL_W){1'b0}}, min_cool_q}) begin
			eval_st = ST_WAIT_MIN;
		end else if (vreg_temp_s1 > vreg_safe_q) begin
			eval_st = ST_WAIT_VREG;
		end else begin
			eval_st = ST_READY;
		end
	end

	// Begin is refused for a zero voltage or frequency.
	assign begin_ok = (action_s1 == ACT_BEGIN) && (volt_s1 != '0) && (freq_s1 != '0);

	// Saved operating point after this transaction.
	assign armed_n      = armed_q || begin_ok;
	assign saved_volt_n = begin_ok ? volt_s1 : saved_volt_q;
	assign saved_freq_n = begin_ok ? freq_s1 : saved_freq_q;

	// Reduced targets: original minus step, floored at the minimum.
	assign volt_limit = {1'b0, min_volt_q} + {{(VOLT_W+1-VSTEP_W){1'b0}}, vstep_q};
	assign freq_limit = {1'b0, min_freq_q} + {{(FREQ_W+1-FSTEP_W){1'b0}}, fstep_q};
	assign tvalid_n   = armed_n && (min_volt_q != '0) && (min_freq_q != '0) &&
	                    (saved_volt_n >= min_volt_q) && (saved_freq_n >= min_freq_q);

	always_comb begin
		red_volt_n = '0;
		red_freq_n = '0;
		if (tvalid_n) begin
			red_volt_n = ({1'b0, saved_volt_n} > volt_limit) ?
			             saved_volt_n - {{(VOLT_W-VSTEP_W){1'b0}}, vstep_q} : min_volt_q;
			red_freq_n = ({1'b0, saved_freq_n} > freq_limit) ?
			             saved_freq_n - {{(FREQ_W-FSTEP_W){1'b0}}, fstep_q} : min_freq_q;
		end
	end

	// Recovery state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q         <= 1'b0;
			start_time_q    <= '0;
			cooling_start_q <= '0;
			saved_volt_q    <= '0;
			saved_freq_q    <= '0;
		end else if (adv) begin
			if (begin_ok) begin
				armed_q         <= 1'b1;
				start_time_q    <= now_s1;
				cooling_start_q <= now_s1;
				saved_volt_q    <= volt_s1;
				saved_freq_q    <= freq_s1;
			end else if (action_s1 == ACT_EVAL && cool_restart) begin
				cooling_start_q <= now_s1;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_free) begin
			res_vld_q <= vld_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			accepted_q <= begin_ok;
			status_q   <= (action_s1 == ACT_EVAL) ? eval_st : ST_INACTIVE;
			tvalid_q   <= tvalid_n;
			red_volt_q <= red_volt_n;
			red_freq_q <= red_freq_n;
		end
	end

	assign result_valid      = res_vld_q;
	assign accepted          = accepted_q;
	assign status            = status_q;
	assign targets_valid     = tvalid_q;
	assign target_voltage_mv = red_volt_q;
	assign reduced_freq_khz  = red_freq_q;

	// Once armed, the block stays armed until reset.
	a_armed_holds: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |=> armed_q)
		else $error("armed flag dropped");

	// An accepted begin leaves the block armed.
	a_begin_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && begin_ok) |=> (armed_q && accepted_q && res_vld_q))
		else $error("accepted begin did not arm");

	// A begin result always carries the inactive status.
	a_begin_status: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && action_s1 == ACT_BEGIN) |=> (status_q == ST_INACTIVE))
		else $error("begin result with nonzero status");

	// An invalid time leaves the cooling timer alone.
	a_invalid_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && action_s1 == ACT_EVAL && eval_st == ST_INVALID) |=> $stable(cooling_start_q))
		else $error("cooling timer changed on invalid time");

	// Valid targets never fall below the configured floors.
	a_targets_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && tvalid_q) |-> (red_volt_q >= min_volt_q && red_freq_q >= min_freq_q))
		else $error("reduced target below its floor");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the overheat recovery gate with a scoreboard and random traffic.
module tb_top;
	import org_pkg::*;

	localparam int CFG_SLOTS       = 1 << CFG_IDX_W;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int SETTLE_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int REPORT_MAX      = 10;

	// One input transaction, field by field.
	typedef struct {
		action_t                   act;
		logic [NOW_W-1:0]          now;
		logic [VOLT_W-1:0]         volt;
		logic [FREQ_W-1:0]         freq;
		logic                      off_ok;
		logic                      vreg_ok;
		logic signed [TEMP_W-1:0]  vreg_t;
		logic                      asic_ok;
		logic signed [TEMP_W-1:0]  asic_t;
	} recovery_item_t;

	// One result transaction.
	typedef struct {
		logic                accepted;
		status_t             status;
		logic                targets_valid;
		logic [VOLT_W-1:0]   volt;
		logic [FREQ_W-1:0]   freq;
	} recovery_result_t;

	typedef logic [CFG_W-1:0] setting_t [CFG_SLOTS];

	// Tracks the recovery state and the register file, and holds the results still owed.
	class recovery_scoreboard;
		logic signed [TEMP_W-1:0] asic_safe;
		logic signed [TEMP_W-1:0] vreg_safe;
		logic [COOL_W-1:0]        min_cool;
		logic [VSTEP_W-1:0]       vstep;
		logic [FSTEP_W-1:0]       fstep;
		logic [VOLT_W-1:0]        min_volt;
		logic [FREQ_W-1:0]        min_freq;

		bit                       armed;
		logic [NOW_W-1:0]         start_ms;
		logic [NOW_W-1:0]         cool_start_ms;
		logic [VOLT_W-1:0]        saved_volt;
		logic [FREQ_W-1:0]        saved_freq;

		recovery_result_t owed_q[$];
		int n_items;
		int n_results;
		int n_mismatch;
		int n_refused;
		int n_targets;
		int status_hits[8];

		function new();
			asic_safe     = ASIC_SAFE_RST;
			vreg_safe     = VREG_SAFE_RST;
			min_cool      = MIN_COOL_RST;
			vstep         = VSTEP_RST;
			fstep         = FSTEP_RST;
			min_volt      = MIN_VOLT_RST;
			min_freq      = MIN_FREQ_RST;
			armed         = 1'b0;
			start_ms      = '0;
			cool_start_ms = '0;
			saved_volt    = '0;
			saved_freq    = '0;
		endfunction

		// Register writes are masked to the register width; unknown indexes do nothing.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_ASIC_SAFE: asic_safe = data[TEMP_W-1:0];
				REG_VREG_SAFE: vreg_safe = data[TEMP_W-1:0];
				REG_MIN_COOL:  min_cool  = data[COOL_W-1:0];
				REG_VSTEP:     vstep     = data[VSTEP_W-1:0];
				REG_FSTEP:     fstep     = data[FSTEP_W-1:0];
				REG_MIN_VOLT:  min_volt  = data[VOLT_W-1:0];
				REG_MIN_FREQ:  min_freq  = data[FREQ_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Works out the result of an accepted transaction and updates the state.
		function void note_item(recovery_item_t it);
			recovery_result_t res;
			int unsigned volt_cut;
			int unsigned freq_cut;
			res = '{accepted: 1'b0, status: ST_INACTIVE, targets_valid: 1'b0,
				volt: '0, freq: '0};
			n_items++;
			if (it.act == ACT_BEGIN) begin
				if (it.volt != 0 && it.freq != 0) begin
					armed         = 1'b1;
					start_ms      = it.now;
					cool_start_ms = it.now;
					saved_volt    = it.volt;
					saved_freq    = it.freq;
					res.accepted  = 1'b1;
				end else begin
					n_refused++;
				end
			end else begin
				// Status checks in priority order.
				if (!armed)
					res.status = ST_INACTIVE;
				else if (it.now < start_ms || it.now < cool_start_ms)
					res.status = ST_INVALID;
				else if (!it.off_ok)
					res.status = ST_WAIT_OFF;
				else if (!it.vreg_ok)
					res.status = ST_WAIT_TELE;
				else if (it.asic_ok && it.asic_t > asic_safe) begin
					cool_start_ms = it.now;
					res.status    = ST_WAIT_ASIC;
				end else if (it.now - cool_start_ms < min_cool)
					res.status = ST_WAIT_MIN;
				else if (it.vreg_t > vreg_safe)
					res.status = ST_WAIT_VREG;
				else
					res.status = ST_READY;
				status_hits[res.status]++;
			end

			// Targets come from the state as it stands after this transaction.
			if (armed && min_volt != 0 && min_freq != 0 &&
				saved_volt >= min_volt && saved_freq >= min_freq) begin
				res.targets_valid = 1'b1;
				volt_cut = 32'(min_volt) + 32'(vstep);
				freq_cut = 32'(min_freq) + 32'(fstep);
				res.volt = (saved_volt > volt_cut) ? saved_volt - vstep : min_volt;
				res.freq = (saved_freq > freq_cut) ? saved_freq - fstep : min_freq;
				n_targets++;
			end
			owed_q.push_back(res);
		endfunction

		// Compares a result with the oldest one owed.
		function void check_result(recovery_result_t got);
			recovery_result_t want;
			if (owed_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= REPORT_MAX)
					$display("error: result with no transaction waiting (st=%0d)", got.status);
			end else begin
				want = owed_q.pop_front();
				n_results++;
				if (got.accepted !== want.accepted || got.status !== want.status ||
					got.targets_valid !== want.targets_valid ||
					got.volt !== want.volt || got.freq !== want.freq) begin
					n_mismatch++;
					if (n_mismatch <= REPORT_MAX)
						$display({"error: result %0d expected acc=%0b st=%0d tv=%0b v=%0d f=%0d,",
							" got acc=%0b st=%0d tv=%0b v=%0d f=%0d"}, n_results,
							want.accepted, want.status, want.targets_valid, want.volt, want.freq,
							got.accepted, got.status, got.targets_valid, got.volt, got.freq);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic action = 1'b0;
	logic [NOW_W-1:0] now_ms = '0;
	logic [VOLT_W-1:0] orig_voltage_mv = '0;
	logic [FREQ_W-1:0] original_freq_khz = '0;
	logic power_off_safe = 1'b0;
	logic vreg_temp_valid = 1'b0;
	logic signed [TEMP_W-1:0] vreg_temp = '0;
	logic asic_temp_valid = 1'b0;
	logic signed [TEMP_W-1:0] asic_temp = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic accepted;
	logic [2:0] status;
	logic targets_valid;
	logic [VOLT_W-1:0] target_voltage_mv;
	logic [FREQ_W-1:0] reduced_freq_khz;

	recovery_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int idle_cycles = 0;
	int n_settings = 0;
	logic [NOW_W-1:0] clock_ms = '0;
	setting_t cur_vals;

	overheat_recovery_gate u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.item_valid          (item_valid),
		.item_stall          (item_stall),
		.action              (action),
		.now_ms              (now_ms),
		.orig_voltage_mv     (orig_voltage_mv),
		.original_freq_khz   (original_freq_khz),
		.power_off_safe      (power_off_safe),
		.vreg_temp_valid     (vreg_temp_valid),
		.vreg_temp           (vreg_temp),
		.asic_temp_valid     (asic_temp_valid),
		.asic_temp           (asic_temp),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.accepted            (accepted),
		.status              (status),
		.targets_valid       (targets_valid),
		.target_voltage_mv   (target_voltage_mv),
		.reduced_freq_khz    (reduced_freq_khz)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver stalls at random at the current rate.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Monitor: checks results, records accepted inputs and runs the watchdog.
	always @(posedge clk) begin
		recovery_item_t seen;
		recovery_result_t got;
		logic took_item;
		logic gave_result;
		took_item   = item_valid && !item_stall;
		gave_result = result_valid && !result_stall;
		if (gave_result) begin
			got.accepted      = accepted;
			got.status        = status_t'(status);
			got.targets_valid = targets_valid;
			got.volt          = target_voltage_mv;
			got.freq          = reduced_freq_khz;
			sb.check_result(got);
		end
		if (took_item) begin
			seen.act     = action_t'(action);
			seen.now     = now_ms;
			seen.volt    = orig_voltage_mv;
			seen.freq    = original_freq_khz;
			seen.off_ok  = power_off_safe;
			seen.vreg_ok = vreg_temp_valid;
			seen.vreg_t  = vreg_temp;
			seen.asic_ok = asic_temp_valid;
			seen.asic_t  = asic_temp;
			sb.note_item(seen);
		end
		if (took_item || gave_result) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic recovery_item_t make_begin(logic [NOW_W-1:0] now,
		logic [VOLT_W-1:0] volt, logic [FREQ_W-1:0] freq);
		recovery_item_t it;
		it.act     = ACT_BEGIN;
		it.now     = now;
		it.volt    = volt;
		it.freq    = freq;
		it.off_ok  = 1'($urandom);
		it.vreg_ok = 1'($urandom);
		it.vreg_t  = TEMP_W'($urandom);
		it.asic_ok = 1'($urandom);
		it.asic_t  = TEMP_W'($urandom);
		return it;
	endfunction

	function automatic recovery_item_t make_eval(logic [NOW_W-1:0] now, logic off_ok,
		logic vreg_ok, logic signed [TEMP_W-1:0] vreg_t, logic asic_ok,
		logic signed [TEMP_W-1:0] asic_t);
		recovery_item_t it;
		it.act     = ACT_EVAL;
		it.now     = now;
		it.volt    = VOLT_W'($urandom);
		it.freq    = FREQ_W'($urandom);
		it.off_ok  = off_ok;
		it.vreg_ok = vreg_ok;
		it.vreg_t  = vreg_t;
		it.asic_ok = asic_ok;
		it.asic_t  = asic_t;
		return it;
	endfunction

	// Mostly well-formed recovery episodes: a begin, then evaluates with time moving on.
	function automatic recovery_item_t next_item();
		recovery_item_t it;
		int pick;
		int unsigned span;
		int v_floor;
		int f_floor;
		int v_step;
		int f_step;
		logic signed [TEMP_W-1:0] asic_ref;
		logic signed [TEMP_W-1:0] vreg_ref;
		pick     = $urandom_range(99);
		asic_ref = cur_vals[REG_ASIC_SAFE][TEMP_W-1:0];
		vreg_ref = cur_vals[REG_VREG_SAFE][TEMP_W-1:0];
		span     = cur_vals[REG_MIN_COOL][COOL_W-1:0] / 4 + 3;
		v_floor  = int'(cur_vals[REG_MIN_VOLT][VOLT_W-1:0]);
		f_floor  = int'(cur_vals[REG_MIN_FREQ][FREQ_W-1:0]);
		v_step   = int'(cur_vals[REG_VSTEP][VSTEP_W-1:0]);
		f_step   = int'(cur_vals[REG_FSTEP][FSTEP_W-1:0]);
		if (pick < 6) begin
			if ($urandom_range(9) == 0)
				clock_ms = NOW_W'({$urandom, $urandom});
			else
				clock_ms += $urandom_range(span);
			it = make_begin(clock_ms, '0, '0);
			// Originals cluster around the floors so that flooring and refusal both occur.
			case ($urandom_range(9))
				0: it.volt = '0;
				1: it.volt = VOLT_W'($urandom);
				default: it.volt = VOLT_W'(v_floor + int'($urandom_range(v_step + 60)) - 20);
			endcase
			case ($urandom_range(9))
				0: it.freq = '0;
				1: it.freq = FREQ_W'($urandom);
				default:
					it.freq = FREQ_W'(f_floor + int'($urandom_range(f_step + 5000)) - 2000);
			endcase
		end else if (pick < 10) begin
			// Noise over the whole range of every field.
			it = make_begin(NOW_W'({$urandom, $urandom}), VOLT_W'($urandom), FREQ_W'($urandom));
			it.act = action_t'($urandom_range(1));
		end else begin
			if ($urandom_range(11) == 0) begin
				it.now = clock_ms - $urandom_range(span) - 1;
			end else begin
				clock_ms += $urandom_range(span);
				it.now = clock_ms;
			end
			it = make_eval(it.now, $urandom_range(15) != 0, $urandom_range(15) != 0,
				TEMP_W'(int'(vreg_ref) + int'($urandom_range(80)) - 40),
				$urandom_range(4) != 0,
				TEMP_W'(int'(asic_ref) + int'($urandom_range(220)) - 200));
		end
		return it;
	endfunction

	function automatic setting_t random_setting();
		setting_t vals;
		vals[REG_ASIC_SAFE] = ($urandom_range(3) == 0) ? CFG_W'($urandom) :
			CFG_W'($urandom_range(4640) - 640);
		vals[REG_VREG_SAFE] = ($urandom_range(3) == 0) ? CFG_W'($urandom) :
			CFG_W'($urandom_range(4640) - 640);
		vals[REG_MIN_COOL] = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(3600000)) :
			CFG_W'($urandom_range(200000));
		vals[REG_VSTEP]    = CFG_W'($urandom_range(1023));
		vals[REG_FSTEP]    = CFG_W'($urandom_range(1048575));
		vals[REG_MIN_VOLT] = ($urandom_range(5) == 0) ? '0 : CFG_W'($urandom_range(65535));
		vals[REG_MIN_FREQ] = ($urandom_range(5) == 0) ? '0 : CFG_W'($urandom_range(4194303));
		vals[REG_UNUSED]   = CFG_W'($urandom);
		return vals;
	endfunction

	// Offers one transaction after a random gap and returns once it is taken.
	task automatic send_item(recovery_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid          <= 1'b1;
		action              <= it.act;
		now_ms              <= it.now;
		orig_voltage_mv     <= it.volt;
		original_freq_khz   <= it.freq;
		power_off_safe      <= it.off_ok;
		vreg_temp_valid     <= it.vreg_ok;
		vreg_temp           <= it.vreg_t;
		asic_temp_valid     <= it.asic_ok;
		asic_temp           <= it.asic_t;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// Writes every register index, the unused one included.
	task automatic apply_setting(setting_t vals);
		for (int r = 0; r < CFG_SLOTS; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= r[CFG_IDX_W-1:0];
			cfg_data  <= vals[r];
			sb.write_reg(r[CFG_IDX_W-1:0], vals[r]);
			@(posedge clk);
		end
		cfg_we   <= 1'b0;
		cur_vals = vals;
		n_settings++;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus and end of run.
	initial begin
		setting_t vals;
		sb = new();
		send_idle_pct = 27;
		recv_idle_pct = 85;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through the status priorities at the reset settings.
		send_item(make_eval(48'd100, 1'b1, 1'b1, 13'sd0, 1'b0, 13'sd0));
		send_item(make_begin(48'd200, 16'd0, 22'd1000));
		send_item(make_begin(48'd300, 16'd900, 22'd0));
		send_item(make_eval(48'd400, 1'b1, 1'b1, 13'sd0, 1'b1, 13'sd4000));
		send_item(make_begin(48'd1000, 16'd900, 22'd500000));
		send_item(make_eval(48'd999, 1'b1, 1'b1, 13'sd0, 1'b0, 13'sd0));
		send_item(make_eval(48'd2000, 1'b0, 1'b1, 13'sd0, 1'b0, 13'sd0));
		send_item(make_eval(48'd2000, 1'b1, 1'b0, 13'sd0, 1'b0, 13'sd0));
		send_item(make_eval(48'd3000, 1'b1, 1'b1, 13'sd0, 1'b1, 13'sd1201));
		send_item(make_eval(48'd2500, 1'b1, 1'b1, 13'sd0, 1'b0, 13'sd0));
		send_item(make_eval(48'd3000, 1'b1, 1'b1, 13'sd0, 1'b1, 13'sd1200));
		send_item(make_eval(48'd63000, 1'b1, 1'b1, 13'sd1361, 1'b0, 13'sd4095));
		send_item(make_eval(48'd63000, 1'b1, 1'b1, 13'sd1360, 1'b1, -13'sd640));
		send_item(make_eval(48'd62999, 1'b1, 1'b1, 13'sd0, 1'b0, 13'sd0));
		send_item(make_begin('1, 16'hFFFF, 22'h3FFFFF));
		send_item(make_eval('1, 1'b1, 1'b1, 13'sh1000, 1'b1, 13'sh1000));
		send_item(make_begin('0, 16'd0, 22'd0));
		send_item(make_eval('0, 1'b1, 1'b1, 13'sd0, 1'b0, 13'sd0));
		send_item(make_eval('1, 1'b0, 1'b0, 13'sd0, 1'b0, 13'sd0));
		item_valid <= 1'b0;
		wait_drained();

		// Random phases; each pair of phases shares an idle pattern, and phases 0 and 5 share a register setting.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase / 2)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (phase)
				0, 5: begin
					vals[REG_ASIC_SAFE] = 22'd1200;
					vals[REG_VREG_SAFE] = 22'd1360;
					vals[REG_MIN_COOL]  = 22'd1000;
					vals[REG_VSTEP]     = 22'd50;
					vals[REG_FSTEP]     = 22'd50000;
					vals[REG_MIN_VOLT]  = 22'd800;
					vals[REG_MIN_FREQ]  = 22'd200000;
					vals[REG_UNUSED]    = CFG_W'($urandom);
				end
				1: begin
					// Lowest values: most negative thresholds, no cooling time, no steps.
					vals[REG_ASIC_SAFE] = 22'h001000;
					vals[REG_VREG_SAFE] = 22'h001000;
					vals[REG_MIN_COOL]  = 22'd0;
					vals[REG_VSTEP]     = 22'd0;
					vals[REG_FSTEP]     = 22'd0;
					vals[REG_MIN_VOLT]  = 22'd1;
					vals[REG_MIN_FREQ]  = 22'd1;
					vals[REG_UNUSED]    = '0;
				end
				2: begin
					// Highest values, with the bits above each register width set.
					vals[REG_ASIC_SAFE] = 22'h3FEFFF;
					vals[REG_VREG_SAFE] = 22'h3FEFFF;
					vals[REG_MIN_COOL]  = 22'h3FFFFF;
					vals[REG_VSTEP]     = 22'h3FFFFF;
					vals[REG_FSTEP]     = 22'h3FFFFF;
					vals[REG_MIN_VOLT]  = 22'h3FFFFF;
					vals[REG_MIN_FREQ]  = 22'h3FFFFF;
					vals[REG_UNUSED]    = 22'h3FFFFF;
				end
				default: vals = random_setting();
			endcase
			apply_setting(vals);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// Halfway through, hold off until every result is back.
				if (i == ITEMS_PER_PHASE / 2) begin
					item_valid <= 1'b0;
					wait_drained();
				end
				send_item(next_item());
			end
			item_valid <= 1'b0;
			wait_drained();
		end

		$display({"Covered %0d transactions (%0d refused begins, %0d with valid targets)",
			" under %0d register settings."},
			sb.n_items, sb.n_refused, sb.n_targets, n_settings + 1);
		$display({"Evaluate outcomes: inactive %0d, wait off %0d, wait telemetry %0d,",
			" wait asic %0d, wait min %0d, wait vreg %0d, ready %0d, invalid %0d."},
			sb.status_hits[ST_INACTIVE], sb.status_hits[ST_WAIT_OFF],
			sb.status_hits[ST_WAIT_TELE], sb.status_hits[ST_WAIT_ASIC],
			sb.status_hits[ST_WAIT_MIN], sb.status_hits[ST_WAIT_VREG],
			sb.status_hits[ST_READY], sb.status_hits[ST_INVALID]);
		if (sb.n_mismatch == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/org_pkg.sv
rtl/core/overheat_recovery_gate.sv
test/tb_top.sv
